// ===== hdl/sain_pkg.sv =====
// ---------------------------------------------------------------------------
// sain_pkg: shared types and constants for suffix array interval narrowing
// Field widths, command codes and the control/status bundles that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package sain_pkg;

  localparam int ADDR_W = 12;  // address, load value, interval bounds
  localparam int IDX_W  = 13;  // working suffix index, may step one past 4095
  localparam int LEN_W  = 13;  // text_length register
  localparam int OFF_W  = 8;   // character offset
  localparam int SYM_W  = 3;   // symbol field of a search

  localparam logic [1:0] CMD_TEXT   = 2'd0;
  localparam logic [1:0] CMD_SUFFIX = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [LEN_W-1:0] TEXT_LENGTH_RST = 13'd4096;

  typedef enum logic [1:0] {
    SRC_S,
    SRC_E,
    SRC_M
  } probe_src_t;

  typedef struct packed {
    logic       accept;      // input transfer this cycle
    logic       init;        // load working registers from a search
    logic       adv;         // skip a short leading suffix
    logic       sa_en;       // suffix array read
    logic       tx_en;       // text read
    logic       set_s_m;
    logic       set_e_m;
    logic       lb_hit;      // lower bound found, restart upper search
    logic       set_end_s;
    logic       mark_empty;
    logic       out_load;
    probe_src_t src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_short;
    logic lt;
    logic eq;
    logic gt;
    logic s_gt_e;
    logic s_eq_e;
    logic s1_lt_e;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hdl/sain_ctrl.sv =====
// ---------------------------------------------------------------------------
// sain_ctrl: search sequencer
// Runs the short-suffix check, the lower-bound and the upper-bound binary
// searches as a series of probes (suffix array read, text read, evaluate) issued to the datapath.
// ---------------------------------------------------------------------------
module sain_ctrl
  import sain_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SA,
    ST_TX,
    ST_EV,
    ST_LBT,
    ST_UBT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_ADV,
    K_CHK,
    K_LB,
    K_LBEND,
    K_UBCHK,
    K_UB,
    K_UBEND
  } kind_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  probe_src_t src_r, src_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    src_nxt   = src_r;
    cmd       = '0;
    cmd.src   = src_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_SEARCH) begin
            cmd.init  = 1'b1;
            kind_nxt  = K_ADV;
            src_nxt   = SRC_S;
            state_nxt = ST_SA;
          end
        end
      end
      ST_SA: begin
        cmd.sa_en = 1'b1;
        state_nxt = ST_TX;
      end
      ST_TX: begin
        cmd.tx_en = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        unique case (kind_r)
          K_ADV: begin
            cmd.adv   = stat.is_short;
            kind_nxt  = K_CHK;
            src_nxt   = SRC_S;
            state_nxt = ST_SA;
          end
          K_CHK: begin
            if (stat.s_gt_e) begin
              cmd.mark_empty = 1'b1;
              state_nxt      = ST_DONE;
            end else if (stat.s_eq_e) begin
              cmd.mark_empty = !stat.eq;
              state_nxt      = ST_DONE;
            end else if (stat.eq) begin
              kind_nxt  = K_UBCHK;
              src_nxt   = SRC_E;
              state_nxt = ST_SA;
            end else begin
              state_nxt = ST_LBT;
            end
          end
          K_LB: begin
            cmd.set_s_m = stat.lt;
            cmd.set_e_m = !stat.lt;
            state_nxt   = ST_LBT;
          end
          K_LBEND: begin
            if (!stat.eq) begin
              cmd.mark_empty = 1'b1;
              state_nxt      = ST_DONE;
            end else begin
              cmd.lb_hit = 1'b1;
              kind_nxt   = K_UBCHK;
              src_nxt    = SRC_E;
              state_nxt  = ST_SA;
            end
          end
          K_UBCHK: begin
            state_nxt = stat.eq ? ST_DONE : ST_UBT;
          end
          K_UB: begin
            cmd.set_e_m = stat.gt;
            cmd.set_s_m = !stat.gt;
            state_nxt   = ST_UBT;
          end
          K_UBEND: begin
            cmd.mark_empty = !stat.eq;
            cmd.set_end_s  = stat.eq;
            state_nxt      = ST_DONE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_LBT: begin
        state_nxt = ST_SA;
        if (stat.s1_lt_e) begin
          kind_nxt = K_LB;
          src_nxt  = SRC_M;
        end else begin
          kind_nxt = K_LBEND;
          src_nxt  = SRC_E;
        end
      end
      ST_UBT: begin
        state_nxt = ST_SA;
        if (stat.s1_lt_e) begin
          kind_nxt = K_UB;
          src_nxt  = SRC_M;
        end else begin
          kind_nxt = K_UBEND;
          src_nxt  = SRC_S;
        end
      end
      ST_DONE: begin
        // wait here while the previous result is still held downstream
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= K_ADV;
      src_r   <= SRC_S;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      src_r   <= src_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ===== hdl/sain_dp.sv =====
// ---------------------------------------------------------------------------
// sain_dp: search datapath
// Text and suffix array memories, interval bound registers, probe pipeline
// (suffix read, text read, compare) and the result register.
// ---------------------------------------------------------------------------
module sain_dp
  import sain_pkg::*;
#(
  parameter int TEXT_DEPTH  = 4096,
  parameter int SYMBOL_BITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_load_value,
  input  logic [ADDR_W-1:0] in_interval_start,
  input  logic [ADDR_W-1:0] in_interval_end,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [OFF_W-1:0]  in_char_offset,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_new_start,
  output logic [ADDR_W-1:0] out_new_end,
  output logic              out_found
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;        // index staging width
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W; // length compare width
  localparam int CW = (SYMBOL_BITS > SYM_W) ? SYMBOL_BITS : SYM_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(TEXT_DEPTH);

  logic [SYMBOL_BITS-1:0] tx_mem [TEXT_DEPTH];
  logic [ADDR_W-1:0]      sa_mem [TEXT_DEPTH];

  logic [LEN_W-1:0]  text_length_r;
  logic [IDX_W-1:0]  s_r, e_r, rs_r;
  logic [ADDR_W-1:0] re_r;
  logic [OFF_W-1:0]  off_r;
  logic [SYM_W-1:0]  sym_r;
  logic              empty_r;

  logic [ADDR_W-1:0]      sa_rd_r;
  logic                   idx_ok_r;
  logic [SYMBOL_BITS-1:0] tx_rd_r;
  logic                   short_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_start_r, out_end_r;
  logic              out_found_r;

  logic [IDX_W:0]    sum;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  probe_idx;
  logic [IW-1:0]     probe_idx_w, pos_w, addr_w;
  logic [LW-1:0]     used_len;
  logic [IDX_W-1:0]  pos;
  logic              wr_ok;
  logic [CW-1:0]     sym_cur, sym_want;

  assign sum = {1'b0, s_r} + {1'b0, e_r};
  assign mid = sum[IDX_W:1];

  always_comb begin
    unique case (cmd.src)
      SRC_S:   probe_idx = s_r;
      SRC_E:   probe_idx = e_r;
      SRC_M:   probe_idx = mid;
      default: probe_idx = s_r;
    endcase
  end

  assign used_len = (LW'(text_length_r) > DEPTH_L) ? DEPTH_L : LW'(text_length_r);

  // suffix start plus offset, out-of-range suffix index reads as position 0
  assign pos   = (idx_ok_r ? IDX_W'(sa_rd_r) : '0) + IDX_W'(off_r);
  assign pos_w = IW'(pos);
  assign probe_idx_w = IW'(probe_idx);
  assign addr_w      = IW'(in_address);
  assign wr_ok       = (LW'(in_address) < DEPTH_L);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok && in_command == CMD_TEXT) begin
      tx_mem[addr_w[AW-1:0]] <= in_load_value[SYMBOL_BITS-1:0];
    end
    if (cmd.tx_en) begin
      tx_rd_r <= tx_mem[pos_w[AW-1:0]];
      short_r <= (LW'(pos) >= used_len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok && in_command == CMD_SUFFIX) begin
      sa_mem[addr_w[AW-1:0]] <= in_load_value;
    end
    if (cmd.sa_en) begin
      sa_rd_r  <= sa_mem[probe_idx_w[AW-1:0]];
      idx_ok_r <= (LW'(probe_idx) < DEPTH_L);
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= TEXT_LENGTH_RST;
    end else if (cfg_we) begin
      text_length_r <= cfg_wdata;
    end
  end

  // interval bounds
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      s_r     <= IDX_W'(in_interval_start);
      e_r     <= IDX_W'(in_interval_end);
      rs_r    <= IDX_W'(in_interval_start);
      re_r    <= in_interval_end;
      off_r   <= in_char_offset;
      sym_r   <= in_symbol;
      empty_r <= 1'b0;
    end else begin
      if (cmd.adv) begin
        s_r  <= s_r + 1'b1;
        rs_r <= rs_r + 1'b1;
      end
      if (cmd.set_s_m) begin
        s_r <= mid;
      end
      if (cmd.set_e_m) begin
        e_r <= mid;
      end
      if (cmd.lb_hit) begin
        rs_r <= e_r;
        s_r  <= e_r;
        e_r  <= IDX_W'(re_r);
      end
      if (cmd.set_end_s) begin
        re_r <= s_r[ADDR_W-1:0];
      end
      if (cmd.mark_empty) begin
        empty_r <= 1'b1;
      end
    end
  end

  // compare stage: a position past the text end reads as symbol zero
  assign sym_cur  = short_r ? '0 : CW'(tx_rd_r);
  assign sym_want = CW'(sym_r);

  always_comb begin
    stat          = '0;
    stat.is_short = short_r;
    stat.lt       = (sym_cur < sym_want);
    stat.eq       = (sym_cur == sym_want);
    stat.gt       = (sym_cur > sym_want);
    stat.s_gt_e   = (s_r > e_r);
    stat.s_eq_e   = (s_r == e_r);
    stat.s1_lt_e  = (({1'b0, s_r} + 1'b1) < {1'b0, e_r});
    stat.out_busy = out_valid_r && !out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (empty_r) begin
        out_start_r <= ADDR_W'(1);
        out_end_r   <= '0;
        out_found_r <= 1'b0;
      end else begin
        out_start_r <= rs_r[ADDR_W-1:0];
        out_end_r   <= re_r;
        out_found_r <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_start = out_start_r;
  assign out_new_end   = out_end_r;
  assign out_found     = out_found_r;

endmodule

// ===== hdl/suffix_array_interval_narrow_core.sv =====
// ---------------------------------------------------------------------------
// suffix_array_interval_narrow_core: suffix array interval narrowing
// Narrows a suffix array interval to the suffixes carrying a given symbol at
// a given character offset, using lower- and upper-bound binary searches.
// ---------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/ready) carries load and search commands. A text or
//   suffix array load is written at the transfer and gives no result; an
//   unknown command is dropped. A search gives one result on the out_*
//   channel: the narrowed interval with out_found set, or start 1, end 0
//   with out_found clear.
//   cfg_we/cfg_wdata writes text_length at any edge; write it only while
//   no search is in flight.
//   Probes: every probe is a suffix array read, a text read and a compare,
//   all through the single read port of each memory. A search makes two
//   probes for the leading suffix and one for the far end, then about
//   log2(interval) probes per bound search, each after a loop test state,
//   then a done state that loads the result. One item is in the block at a
//   time. The next item is accepted while the previous result is still
//   waiting; a search that finishes while the previous result is still
//   waiting holds until it drains.
//   Reset clears the sequencer, the output valid and sets text_length to
//   4096. Memory contents are undefined until loaded.
// ---------------------------------------------------------------------------
module suffix_array_interval_narrow_core
  import sain_pkg::*;
#(
  parameter int TEXT_DEPTH  = 4096,
  parameter int SYMBOL_BITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_load_value,
  input  logic [ADDR_W-1:0] in_interval_start,
  input  logic [ADDR_W-1:0] in_interval_end,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [OFF_W-1:0]  in_char_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_new_start,
  output logic [ADDR_W-1:0] out_new_end,
  output logic              out_found,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  sain_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sain_dp #(
    .TEXT_DEPTH  (TEXT_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_load_value     (in_load_value),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_symbol         (in_symbol),
    .in_char_offset    (in_char_offset),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_start     (out_new_start),
    .out_new_end       (out_new_end),
    .out_found         (out_found)
  );

endmodule

// ===== verif/sain_interval_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sain_interval_checker: result checker for suffix array interval narrowing
// Watches the load/search and result channels, keeps its own copy of the
// text, the suffix array and text_length, predicts the narrowed interval of
// every accepted search and compares each result transfer in order.
// ---------------------------------------------------------------------------
module sain_interval_checker
  import sain_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_load_value,
  input  logic [ADDR_W-1:0] in_interval_start,
  input  logic [ADDR_W-1:0] in_interval_end,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [OFF_W-1:0]  in_char_offset,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ADDR_W-1:0] out_new_start,
  input  logic [ADDR_W-1:0] out_new_end,
  input  logic              out_found,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              run_done,
  output int                fail_count,
  output int                hit_count
);

  localparam int DEPTH = 4096;

  typedef struct packed {
    logic [ADDR_W-1:0] new_start;
    logic [ADDR_W-1:0] new_end;
    logic              found;
  } interval_t;

  logic [SYM_W-1:0]  text_mem   [DEPTH];
  logic [ADDR_W-1:0] suffix_mem [DEPTH];
  logic [LEN_W-1:0]  text_len = TEXT_LENGTH_RST;
  interval_t         pending_intervals [$];
  bit                leftovers_checked = 1'b0;

  function automatic int span();
    return (text_len > DEPTH) ? DEPTH : int'(text_len);
  endfunction

  function automatic int suffix_pos(int row);
    return (row < DEPTH) ? int'(suffix_mem[row]) : 0;
  endfunction

  // symbols past the end of the text read as 0
  function automatic int symbol_of(int row, int off);
    int pos;
    pos = suffix_pos(row) + off;
    return (pos < span()) ? int'(text_mem[pos]) : 0;
  endfunction

  function automatic interval_t narrow_interval(int lo_in, int hi_in, int c, int off);
    interval_t res;
    int        first, last, s, e, m;
    bit        empty;
    first = lo_in;
    last  = hi_in;
    s     = lo_in;
    e     = hi_in;
    empty = 1'b0;
    // leading suffix too short for the offset: skip it
    if (suffix_pos(s) + off >= span()) begin
      first++;
      s++;
    end
    if (s > e) begin
      empty = 1'b1;
    end else if (s == e) begin
      if (symbol_of(s, off) != c) empty = 1'b1;
    end else begin
      if (symbol_of(s, off) != c) begin
        while (s + 1 < e) begin
          m = (s + e) / 2;
          if (symbol_of(m, off) < c) s = m;
          else e = m;
        end
        if (symbol_of(e, off) != c) begin
          empty = 1'b1;
        end else begin
          first = e;
          s     = e;
          e     = hi_in;
        end
      end
      if (!empty && symbol_of(e, off) != c) begin
        while (s + 1 < e) begin
          m = (s + e) / 2;
          if (symbol_of(m, off) > c) e = m;
          else s = m;
        end
        if (symbol_of(s, off) != c) empty = 1'b1;
        else last = s;
      end
    end
    if (empty) begin
      res.new_start = ADDR_W'(1);
      res.new_end   = '0;
      res.found     = 1'b0;
    end else begin
      res.new_start = first[ADDR_W-1:0];
      res.new_end   = last[ADDR_W-1:0];
      res.found     = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    interval_t want;
    if (!rst_n) begin
      pending_intervals.delete();
      text_len   = TEXT_LENGTH_RST;
      fail_count = 0;
      hit_count  = 0;
    end else begin
      if (cfg_we) text_len = cfg_wdata;

      // results first, so a search accepted at this edge cannot cover a stray result
      if (out_valid && out_ready) begin
        if (pending_intervals.size() == 0) begin
          $error("result with no search outstanding: start %0d end %0d found %0b",
                 out_new_start, out_new_end, out_found);
          fail_count++;
        end else begin
          want = pending_intervals.pop_front();
          if (out_new_start !== want.new_start) begin
            $error("new_start: expected %0d, got %0d", want.new_start, out_new_start);
            fail_count++;
          end
          if (out_new_end !== want.new_end) begin
            $error("new_end: expected %0d, got %0d", want.new_end, out_new_end);
            fail_count++;
          end
          if (out_found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_found);
            fail_count++;
          end
          if (want.found) hit_count++;
        end
      end

      if (in_valid && in_ready) begin
        case (in_command)
          CMD_TEXT:   text_mem[in_address] = in_load_value[SYM_W-1:0];
          CMD_SUFFIX: suffix_mem[in_address] = in_load_value;
          CMD_SEARCH: pending_intervals = {pending_intervals, narrow_interval(
                        int'(in_interval_start), int'(in_interval_end),
                        int'(in_symbol), int'(in_char_offset))};
          default: ;
        endcase
      end

      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_intervals.size() != 0) begin
          $error("%0d expected results never arrived", pending_intervals.size());
          fail_count += pending_intervals.size();
        end
      end
    end
  end

endmodule

// ===== verif/suffix_array_interval_narrow_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// suffix_array_interval_narrow_core_tb: testbench for interval narrowing
// Loads small random texts with their sorted suffix arrays, then issues
// searches built from real prefixes of the text plus random and corner
// searches, under several text lengths and sender/receiver idle patterns.
// Results are checked by sain_interval_checker.
// ---------------------------------------------------------------------------
module suffix_array_interval_narrow_core_tb;
  import sain_pkg::*;

  localparam logic [1:0] CMD_NONE    = 2'd3;  // unknown, dropped by the block
  localparam int         NUM_PHASES  = 8;
  localparam int         PHASE_ITEMS = 125;
  localparam int         SETTLE      = 200;
  localparam int         PHASE_LEN [NUM_PHASES] = '{32, 1, 48, 16, 64, 8, 40, 24};

  logic              clk;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic [1:0]        in_command        = CMD_TEXT;
  logic [ADDR_W-1:0] in_address        = '0;
  logic [ADDR_W-1:0] in_load_value     = '0;
  logic [ADDR_W-1:0] in_interval_start = '0;
  logic [ADDR_W-1:0] in_interval_end   = '0;
  logic [SYM_W-1:0]  in_symbol         = '0;
  logic [OFF_W-1:0]  in_char_offset    = '0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [ADDR_W-1:0] out_new_start;
  logic [ADDR_W-1:0] out_new_end;
  logic              out_found;
  logic              cfg_we            = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata         = '0;
  logic              run_done          = 1'b0;
  int                check_fails;
  int                check_hits;

  // what has been loaded so far, used to keep searches on written entries
  logic [SYM_W-1:0]  text_img [4096];
  bit                text_ok  [4096];
  logic [ADDR_W-1:0] sa_img   [4096];
  bit                sa_ok    [4096];
  int                cur_len        = 4096;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit burst_req      = 1'b0;
  int searches_sent  = 0;
  int results_seen   = 0;
  int loads_sent     = 0;
  int settings_used  = 0;

  suffix_array_interval_narrow_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_load_value     (in_load_value),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_symbol         (in_symbol),
    .in_char_offset    (in_char_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_start     (out_new_start),
    .out_new_end       (out_new_end),
    .out_found         (out_found),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  sain_interval_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_load_value     (in_load_value),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_symbol         (in_symbol),
    .in_char_offset    (in_char_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_start     (out_new_start),
    .out_new_end       (out_new_end),
    .out_found         (out_found),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .run_done          (run_done),
    .fail_count        (check_fails),
    .hit_count         (check_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout: block stopped making progress");
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_seen++;
      if (burst_req) begin
        burst_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic drive(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr, val, lo, hi,
                       input logic [SYM_W-1:0] sym, input logic [OFF_W-1:0] off);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_address        <= addr;
    in_load_value     <= val;
    in_interval_start <= lo;
    in_interval_end   <= hi;
    in_symbol         <= sym;
    in_char_offset    <= off;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_SEARCH) searches_sent++;
    else if (cmd != CMD_NONE) loads_sent++;
  endtask

  task automatic load_text(input int addr, input int val);
    text_img[addr] = val[SYM_W-1:0];
    text_ok[addr]  = 1'b1;
    drive(CMD_TEXT, ADDR_W'(addr), ADDR_W'(val), ADDR_W'($urandom), ADDR_W'($urandom),
          SYM_W'($urandom), OFF_W'($urandom));
  endtask

  task automatic load_suffix(input int addr, input int val);
    sa_img[addr] = ADDR_W'(val);
    sa_ok[addr]  = 1'b1;
    drive(CMD_SUFFIX, ADDR_W'(addr), ADDR_W'(val), ADDR_W'($urandom), ADDR_W'($urandom),
          SYM_W'($urandom), OFF_W'($urandom));
  endtask

  task automatic search(input int lo, input int hi, input int sym, input int off);
    drive(CMD_SEARCH, ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'(lo), ADDR_W'(hi),
          SYM_W'(sym), OFF_W'(off));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (searches_sent != results_seen) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_len = int'(v);
    settings_used++;
  endtask

  // true when every suffix row and text symbol the search may touch was loaded
  function automatic bit reads_written(int lo, int hi, int off);
    int used, top_row, r, pos;
    used    = (cur_len > 4096) ? 4096 : cur_len;
    top_row = (hi > lo) ? hi : lo + 1;
    if (top_row > 4095) top_row = 4095;
    for (r = lo; r <= top_row; r++) begin
      if (!sa_ok[r]) return 1'b0;
      pos = int'(sa_img[r]) + off;
      if (pos < used && !text_ok[pos]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // suffix order with end of text below every symbol
  function automatic bit suffix_before(int a, int b, int n);
    int j;
    for (j = 0; j <= n; j++) begin
      if (a + j >= n) return 1'b1;
      if (b + j >= n) return 1'b0;
      if (text_img[a + j] != text_img[b + j]) return text_img[a + j] < text_img[b + j];
    end
    return 1'b0;
  endfunction

  function automatic bit row_has_prefix(int r, int p, int k, int n);
    int q, j;
    q = int'(sa_img[r]);
    if (q + k > n) return 1'b0;
    for (j = 0; j < k; j++)
      if (text_img[q + j] != text_img[p + j]) return 1'b0;
    return 1'b1;
  endfunction

  // random text of n symbols, a few pad symbols, then its sorted suffix array
  task automatic build_text(input int n);
    int alpha, i, j;
    int order [$];
    alpha = $urandom_range(2, 8);
    for (i = 0; i < n + 4; i++)
      load_text(i, $urandom_range(0, alpha - 1) | ($urandom_range(0, 511) << SYM_W));
    for (i = 0; i < n; i++) begin
      j = 0;
      while (j < order.size() && suffix_before(order[j], i, n)) j++;
      order.insert(j, i);
    end
    for (i = 0; i < n; i++) load_suffix(i, order[i]);
    load_suffix(n, 0);  // spare row so a one-row interval never looks past the end
  endtask

  task automatic pick_search(input int n, output int lo, output int hi,
                             output int sym, output int off);
    int tries, roll, p, k, r;
    for (tries = 0; tries < 40; tries++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        // rows sharing a real prefix of the text, narrowed by its next symbol
        p  = $urandom_range(0, n - 1);
        k  = $urandom_range(0, n - p);
        lo = -1;
        hi = 0;
        for (r = 0; r < n; r++) begin
          if (row_has_prefix(r, p, k, n)) begin
            if (lo < 0) lo = r;
            hi = r;
          end
        end
        if (lo < 0) begin
          lo = 0;
          hi = n - 1;
        end
        if (lo > 0 && $urandom_range(0, 99) < 15) lo--;
        sym = (p + k < n && $urandom_range(0, 99) < 65) ? int'(text_img[p + k])
                                                       : $urandom_range(0, 7);
        off = k;
      end else if (roll < 95) begin
        lo  = $urandom_range(0, n);
        hi  = $urandom_range(0, n);
        sym = $urandom_range(0, 7);
        off = $urandom_range(0, 255);
      end else begin
        lo  = $urandom_range(4094, 4095);
        hi  = $urandom_range(4094, 4095);
        sym = $urandom_range(0, 7);
        off = $urandom_range(0, 255);
      end
      if (reads_written(lo, hi, off)) return;
    end
    lo  = 0;
    hi  = n - 1;
    sym = $urandom_range(0, 7);
    off = 0;
  endtask

  initial begin
    int ph, n, items, roll, lo, hi, sym, off;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sorted five-symbol text plus rows at the top of the store
    load_text(0, 0);
    load_text(1, 2);
    load_text(2, 5);
    load_text(3, 7);
    load_text(4, 4095);
    load_text(4095, 4095);
    for (int i = 0; i < 5; i++) load_suffix(i, i);
    load_suffix(4094, 4);
    load_suffix(4095, 4095);
    search(0, 4, 7, 0);
    search(0, 4, 5, 0);
    search(0, 4, 0, 0);
    search(0, 4, 3, 0);
    search(4094, 4095, 7, 0);
    search(4095, 4095, 0, 255);  // short leading suffix steps past the last row
    search(2, 1, 0, 0);          // reversed interval
    drive(CMD_NONE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 3'h7, 8'hFF);
    settle();
    write_length(1);
    search(1, 4, 0, 0);
    search(0, 4, 0, 0);
    settle();
    write_length(8191);  // oversized, acts as the full store
    search(0, 4, 7, 0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      n = PHASE_LEN[ph];
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 2) write_length(4096);
      else if (ph == 4) write_length(8191);
      else if (ph == 6) write_length(LEN_W'(n + 4));
      else write_length(LEN_W'(n));
      build_text(n);

      items = 0;
      while (items < PHASE_ITEMS) begin
        if (ph == 4 && items == 40) burst_req = 1'b1;
        if (ph == 6 && items == 60) drain();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // stray loads away from the rows in use
          if ($urandom_range(0, 1)) load_text($urandom_range(128, 4095), $urandom_range(0, 4095));
          else load_suffix($urandom_range(128, 4095), $urandom_range(0, 4095));
          items++;
        end else if (roll < 10) begin
          drive(CMD_NONE, ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                ADDR_W'($urandom), SYM_W'($urandom), OFF_W'($urandom));
        end else begin
          pick_search(n, lo, hi, sym, off);
          search(lo, hi, sym, off);
          items++;
        end
      end
    end

    settle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d loads and %0d searches (%0d found)", loads_sent, searches_sent,
             check_hits);
    $display("over %0d text length settings and four idle patterns", settings_used + 1);
    if (check_fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
